// ===== hdl/scc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package scc_pkg;

    // Field widths of the point stream and the registers.
    localparam int COORD_W = 24;
    localparam int RAD_W   = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int CNT_W   = 2;

    // Shared multiplier and accumulator widths.
    localparam int MUL_W   = 33;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int ACC_W   = 101;
    localparam int L2_W    = 50;
    localparam int DOT_W   = 51;
    localparam int CRS_W   = 50;
    localparam int HALF_W  = 25;
    localparam int R2_W    = 2 * RAD_W;

    // Configuration port.
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = 3;

    localparam logic [IDX_W-1:0] REG_ANCHOR_X = 3'd0;
    localparam logic [IDX_W-1:0] REG_ANCHOR_Y = 3'd1;
    localparam logic [IDX_W-1:0] REG_GOAL_X   = 3'd2;
    localparam logic [IDX_W-1:0] REG_GOAL_Y   = 3'd3;
    localparam logic [IDX_W-1:0] REG_GOAL_Z   = 3'd4;
    localparam logic [IDX_W-1:0] REG_RADIUS   = 3'd5;
    localparam logic [IDX_W-1:0] REG_VCLEAR   = 3'd6;

    localparam logic [RAD_W-1:0] RADIUS_RST = 16'd128;
    localparam logic [RAD_W-1:0] VCLEAR_RST = 16'd256;
    localparam logic [CNT_W-1:0] CNT_SAT    = 2'd2;

    // Multiplier operand sources.
    localparam int OPD_W = 4;
    localparam logic [OPD_W-1:0] OPD_SX = 4'd0;
    localparam logic [OPD_W-1:0] OPD_SY = 4'd1;
    localparam logic [OPD_W-1:0] OPD_AX = 4'd2;
    localparam logic [OPD_W-1:0] OPD_AY = 4'd3;
    localparam logic [OPD_W-1:0] OPD_GX = 4'd4;
    localparam logic [OPD_W-1:0] OPD_GY = 4'd5;
    localparam logic [OPD_W-1:0] OPD_R  = 4'd6;
    localparam logic [OPD_W-1:0] OPD_CH = 4'd7;
    localparam logic [OPD_W-1:0] OPD_CL = 4'd8;
    localparam logic [OPD_W-1:0] OPD_R2 = 4'd9;
    localparam logic [OPD_W-1:0] OPD_LH = 4'd10;
    localparam logic [OPD_W-1:0] OPD_LL = 4'd11;

    // Accumulator operations on the previous step's product.
    localparam int ACC_OP_W = 3;
    localparam logic [ACC_OP_W-1:0] ACC_NONE = 3'd0;
    localparam logic [ACC_OP_W-1:0] ACC_LOAD = 3'd1;
    localparam logic [ACC_OP_W-1:0] ACC_NEG  = 3'd2;
    localparam logic [ACC_OP_W-1:0] ACC_ADD  = 3'd3;
    localparam logic [ACC_OP_W-1:0] ACC_SUB  = 3'd4;

    // Left shift applied to the product before accumulation.
    localparam int SH_W = 2;
    localparam logic [SH_W-1:0] SH_0  = 2'd0;
    localparam logic [SH_W-1:0] SH_25 = 2'd1;
    localparam logic [SH_W-1:0] SH_26 = 2'd2;
    localparam logic [SH_W-1:0] SH_50 = 2'd3;

    // Where the current accumulator value is saved.
    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_NONE  = 3'd0;
    localparam logic [ST_W-1:0] ST_L2    = 3'd1;
    localparam logic [ST_W-1:0] ST_DOT   = 3'd2;
    localparam logic [ST_W-1:0] ST_CROSS = 3'd3;
    localparam logic [ST_W-1:0] ST_R2    = 3'd4;

    // Sequencing.
    localparam int SEQ_W = 2;
    localparam logic [SEQ_W-1:0] SEQ_NEXT = 2'd0;
    localparam logic [SEQ_W-1:0] SEQ_JUMP = 2'd1;
    localparam logic [SEQ_W-1:0] SEQ_END  = 2'd2;

    localparam logic COND_ANCHOR = 1'b0;
    localparam logic COND_GOAL   = 1'b1;

    localparam int PC_W = 5;
    localparam logic [PC_W-1:0] PC_ANCHOR = 5'd20;
    localparam logic [PC_W-1:0] PC_GOAL   = 5'd25;

    typedef struct packed {
        logic [OPD_W-1:0]    opa;
        logic [OPD_W-1:0]    opb;
        logic [ACC_OP_W-1:0] acc;
        logic [SH_W-1:0]     sh;
        logic [ST_W-1:0]     st;
        logic [SEQ_W-1:0]    seq;
        logic                cond;
        logic [PC_W-1:0]     tgt;
    } t_ctl;

    typedef struct packed {
        logic anchor;
        logic goal;
        logic acc_nonneg;
    } t_flags;

    function automatic t_ctl scc_cw(
        input logic [OPD_W-1:0]    opa,
        input logic [OPD_W-1:0]    opb,
        input logic [ACC_OP_W-1:0] acc,
        input logic [SH_W-1:0]     sh,
        input logic [ST_W-1:0]     st,
        input logic [SEQ_W-1:0]    seq,
        input logic                cond,
        input logic [PC_W-1:0]     tgt
    );
        t_ctl c;
        c.opa  = opa;
        c.opb  = opb;
        c.acc  = acc;
        c.sh   = sh;
        c.st   = st;
        c.seq  = seq;
        c.cond = cond;
        c.tgt  = tgt;
        return c;
    endfunction

    // Microprogram. The multiply of a step lands in the product register;
    // the accumulator consumes it in the following step. A store saves the
    // accumulator as it stands at the start of the step.
    function automatic t_ctl scc_ucode(input logic [PC_W-1:0] pc);
        t_ctl c;
        case (pc)
            // l2 = sx*sx + sy*sy
            5'd0:  c = scc_cw(OPD_SX, OPD_SX, ACC_NONE, SH_0, ST_NONE, SEQ_NEXT,
                              COND_ANCHOR, '0);
            5'd1:  c = scc_cw(OPD_SY, OPD_SY, ACC_LOAD, SH_0, ST_NONE, SEQ_NEXT,
                              COND_ANCHOR, '0);
            5'd2:  c = scc_cw(OPD_AX, OPD_SX, ACC_ADD, SH_0, ST_NONE, SEQ_NEXT,
                              COND_ANCHOR, '0);
            // dot = ax*sx + ay*sy
            5'd3:  c = scc_cw(OPD_AY, OPD_SY, ACC_LOAD, SH_0, ST_L2, SEQ_NEXT,
                              COND_ANCHOR, '0);
            5'd4:  c = scc_cw(OPD_AX, OPD_SY, ACC_ADD, SH_0, ST_NONE, SEQ_NEXT,
                              COND_ANCHOR, '0);
            // cross = ax*sy - ay*sx
            5'd5:  c = scc_cw(OPD_AY, OPD_SX, ACC_LOAD, SH_0, ST_DOT, SEQ_NEXT,
                              COND_ANCHOR, '0);
            5'd6:  c = scc_cw(OPD_R, OPD_R, ACC_SUB, SH_0, ST_NONE, SEQ_NEXT,
                              COND_ANCHOR, '0);
            5'd7:  c = scc_cw(OPD_R, OPD_R, ACC_LOAD, SH_0, ST_CROSS, SEQ_NEXT,
                              COND_ANCHOR, '0);
            // Pick the case, and start cross squared as -(h*h << 50) ...
            5'd8:  c = scc_cw(OPD_CH, OPD_CH, ACC_NONE, SH_0, ST_R2, SEQ_JUMP,
                              COND_ANCHOR, PC_ANCHOR);
            5'd9:  c = scc_cw(OPD_CH, OPD_CL, ACC_NEG, SH_50, ST_NONE, SEQ_JUMP,
                              COND_GOAL, PC_GOAL);
            // ... - (h*l << 26) - l*l + (r2*lh << 25) + r2*ll
            5'd10: c = scc_cw(OPD_CL, OPD_CL, ACC_SUB, SH_26, ST_NONE, SEQ_NEXT,
                              COND_ANCHOR, '0);
            5'd11: c = scc_cw(OPD_R2, OPD_LH, ACC_SUB, SH_0, ST_NONE, SEQ_NEXT,
                              COND_ANCHOR, '0);
            5'd12: c = scc_cw(OPD_R2, OPD_LL, ACC_ADD, SH_25, ST_NONE, SEQ_NEXT,
                              COND_ANCHOR, '0);
            5'd13: c = scc_cw(OPD_R, OPD_R, ACC_ADD, SH_0, ST_NONE, SEQ_NEXT,
                              COND_ANCHOR, '0);
            // Distance to the anchor: r*r - ax*ax - ay*ay
            5'd20: c = scc_cw(OPD_AX, OPD_AX, ACC_NONE, SH_0, ST_NONE, SEQ_NEXT,
                              COND_ANCHOR, '0);
            5'd21: c = scc_cw(OPD_AY, OPD_AY, ACC_NEG, SH_0, ST_NONE, SEQ_NEXT,
                              COND_ANCHOR, '0);
            5'd22: c = scc_cw(OPD_R, OPD_R, ACC_SUB, SH_0, ST_NONE, SEQ_NEXT,
                              COND_ANCHOR, '0);
            5'd23: c = scc_cw(OPD_R, OPD_R, ACC_ADD, SH_0, ST_NONE, SEQ_NEXT,
                              COND_ANCHOR, '0);
            // Distance to the goal: r*r - gx*gx - gy*gy
            5'd25: c = scc_cw(OPD_GX, OPD_GX, ACC_NONE, SH_0, ST_NONE, SEQ_NEXT,
                              COND_ANCHOR, '0);
            5'd26: c = scc_cw(OPD_GY, OPD_GY, ACC_NEG, SH_0, ST_NONE, SEQ_NEXT,
                              COND_ANCHOR, '0);
            5'd27: c = scc_cw(OPD_R, OPD_R, ACC_SUB, SH_0, ST_NONE, SEQ_NEXT,
                              COND_ANCHOR, '0);
            5'd28: c = scc_cw(OPD_R, OPD_R, ACC_ADD, SH_0, ST_NONE, SEQ_NEXT,
                              COND_ANCHOR, '0);
            // Steps 14, 24 and 29 end the point: near when the sum is >= 0.
            default: c = scc_cw(OPD_R, OPD_R, ACC_NONE, SH_0, ST_NONE, SEQ_END,
                                COND_ANCHOR, '0);
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/scc_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module scc_datapath import scc_pkg::*; (
    input  wire logic                       i_clk,
    input  wire logic                       i_load,
    input  wire logic                       i_run,
    input  wire logic signed [COORD_W-1:0]  i_point_x,
    input  wire logic signed [COORD_W-1:0]  i_point_y,
    input  wire logic signed [COORD_W-1:0]  i_anchor_x,
    input  wire logic signed [COORD_W-1:0]  i_anchor_y,
    input  wire logic signed [COORD_W-1:0]  i_goal_x,
    input  wire logic signed [COORD_W-1:0]  i_goal_y,
    input  wire logic        [RAD_W-1:0]    i_radius,
    input  wire t_ctl                       i_ctl,
    output t_flags                          o_flags
);

    logic signed [DIFF_W-1:0] r_sx, r_sy, r_ax, r_ay, r_gx, r_gy;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic        [L2_W-1:0]   r_l2;
    logic signed [DOT_W-1:0]  r_dot;
    logic        [CRS_W-1:0]  r_crs;
    logic        [R2_W-1:0]   r_r2;

    logic signed [MUL_W-1:0]  w_a, w_b;
    logic signed [ACC_W-1:0]  w_term, w_abs, n_acc;

    // Operand selection for the shared multiplier.
    function automatic logic signed [MUL_W-1:0] pick(input logic [OPD_W-1:0] sel,
        input logic signed [DIFF_W-1:0] sx, input logic signed [DIFF_W-1:0] sy,
        input logic signed [DIFF_W-1:0] ax, input logic signed [DIFF_W-1:0] ay,
        input logic signed [DIFF_W-1:0] gx, input logic signed [DIFF_W-1:0] gy,
        input logic [RAD_W-1:0] r, input logic [CRS_W-1:0] crs,
        input logic [R2_W-1:0] r2, input logic [L2_W-1:0] l2);
        logic signed [MUL_W-1:0] v;
        case (sel)
            OPD_SX:  v = MUL_W'(sx);
            OPD_SY:  v = MUL_W'(sy);
            OPD_AX:  v = MUL_W'(ax);
            OPD_AY:  v = MUL_W'(ay);
            OPD_GX:  v = MUL_W'(gx);
            OPD_GY:  v = MUL_W'(gy);
            OPD_R:   v = $signed(MUL_W'(r));
            OPD_CH:  v = $signed(MUL_W'(crs[CRS_W-1:HALF_W]));
            OPD_CL:  v = $signed(MUL_W'(crs[HALF_W-1:0]));
            OPD_R2:  v = $signed(MUL_W'(r2));
            OPD_LH:  v = $signed(MUL_W'(l2[L2_W-1:HALF_W]));
            OPD_LL:  v = $signed(MUL_W'(l2[HALF_W-1:0]));
            default: v = '0;
        endcase
        return v;
    endfunction

    assign w_a = pick(i_ctl.opa, r_sx, r_sy, r_ax, r_ay, r_gx, r_gy, i_radius,
                      r_crs, r_r2, r_l2);
    assign w_b = pick(i_ctl.opb, r_sx, r_sy, r_ax, r_ay, r_gx, r_gy, i_radius,
                      r_crs, r_r2, r_l2);

    // Aligned product and the next accumulator value.
    always_comb begin
        case (i_ctl.sh)
            SH_25:   w_term = ACC_W'(r_prod) <<< 25;
            SH_26:   w_term = ACC_W'(r_prod) <<< 26;
            SH_50:   w_term = ACC_W'(r_prod) <<< 50;
            default: w_term = ACC_W'(r_prod);
        endcase
        case (i_ctl.acc)
            ACC_LOAD: n_acc = w_term;
            ACC_NEG:  n_acc = -w_term;
            ACC_ADD:  n_acc = r_acc + w_term;
            ACC_SUB:  n_acc = r_acc - w_term;
            default:  n_acc = r_acc;
        endcase
    end

    assign w_abs = r_acc[ACC_W-1] ? -r_acc : r_acc;

    // Offsets are taken when a point is accepted; the rest runs per step.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sx <= DIFF_W'(i_goal_x) - DIFF_W'(i_anchor_x);
            r_sy <= DIFF_W'(i_goal_y) - DIFF_W'(i_anchor_y);
            r_ax <= DIFF_W'(i_point_x) - DIFF_W'(i_anchor_x);
            r_ay <= DIFF_W'(i_point_y) - DIFF_W'(i_anchor_y);
            r_gx <= DIFF_W'(i_point_x) - DIFF_W'(i_goal_x);
            r_gy <= DIFF_W'(i_point_y) - DIFF_W'(i_goal_y);
        end else if (i_run) begin
            r_prod <= w_a * w_b;
            r_acc  <= n_acc;
            case (i_ctl.st)
                ST_L2:    r_l2  <= r_acc[L2_W-1:0];
                ST_DOT:   r_dot <= r_acc[DOT_W-1:0];
                ST_CROSS: r_crs <= w_abs[CRS_W-1:0];
                ST_R2:    r_r2  <= r_acc[R2_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Branch and result conditions.
    assign o_flags.anchor     = (r_l2 == '0) || (r_dot <= 0);
    assign o_flags.goal       = r_dot >= $signed({1'b0, r_l2});
    assign o_flags.acc_nonneg = ~r_acc[ACC_W-1];

endmodule

`default_nettype wire

// ===== hdl/segment_clearance_check.sv =====
// A point occupies the block from its accept beat to its end step, a shorter path
// when its projection falls at or before the anchor; the input stalls meanwhile.
// The result is registered from the end step of the last point. The microprogram runs
// all 10 to 12 products of a point through one shared 33x33 multiplier.
// Reset (synchronous, active low) clears the count, sequencer and output valid,
// and loads the register defaults (radius 128, vertical clearance 256, rest 0).
`timescale 1ns / 1ps
`default_nettype none

module segment_clearance_check import scc_pkg::*; (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic signed [COORD_W-1:0] i_point_x,
    input  wire logic signed [COORD_W-1:0] i_point_y,
    input  wire logic signed [COORD_W-1:0] i_point_z,
    input  wire logic                      i_last_point,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic                           o_obstructed,
    output logic             [CNT_W-1:0]   o_near_points,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic        [ADDR_W-1:0]  paddr,
    input  wire logic        [DATA_W-1:0]  pwdata,
    output logic             [DATA_W-1:0]  prdata,
    output logic                           pready
);

    logic signed [COORD_W-1:0] r_anchor_x, r_anchor_y, r_goal_x, r_goal_y, r_goal_z;
    logic        [RAD_W-1:0]   r_radius, r_vclear;

    logic                      r_busy, n_busy;
    logic        [PC_W-1:0]    r_pc, n_pc;
    logic                      r_last, r_zok;
    logic        [CNT_W-1:0]   r_count, n_count;
    logic                      r_out_valid, r_obstructed;
    logic        [CNT_W-1:0]   r_near;

    logic                      w_accept, w_wr, w_end, w_fin, w_near, w_cond;
    logic        [IDX_W-1:0]   w_idx;
    logic signed [DIFF_W-1:0]  w_dz, w_dz_abs;
    t_ctl                      w_ctl;
    t_flags                    w_flags;

    // Register file.
    assign pready = 1'b1;
    assign w_idx  = paddr[ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_anchor_x <= '0;
            r_anchor_y <= '0;
            r_goal_x   <= '0;
            r_goal_y   <= '0;
            r_goal_z   <= '0;
            r_radius   <= RADIUS_RST;
            r_vclear   <= VCLEAR_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_ANCHOR_X: r_anchor_x <= pwdata[COORD_W-1:0];
                REG_ANCHOR_Y: r_anchor_y <= pwdata[COORD_W-1:0];
                REG_GOAL_X:   r_goal_x   <= pwdata[COORD_W-1:0];
                REG_GOAL_Y:   r_goal_y   <= pwdata[COORD_W-1:0];
                REG_GOAL_Z:   r_goal_z   <= pwdata[COORD_W-1:0];
                REG_RADIUS:   r_radius   <= pwdata[RAD_W-1:0];
                REG_VCLEAR:   r_vclear   <= pwdata[RAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register readback, signed values sign extended.
    always_comb begin
        case (w_idx)
            REG_ANCHOR_X: prdata = DATA_W'(r_anchor_x);
            REG_ANCHOR_Y: prdata = DATA_W'(r_anchor_y);
            REG_GOAL_X:   prdata = DATA_W'(r_goal_x);
            REG_GOAL_Y:   prdata = DATA_W'(r_goal_y);
            REG_GOAL_Z:   prdata = DATA_W'(r_goal_z);
            REG_RADIUS:   prdata = DATA_W'(r_radius);
            REG_VCLEAR:   prdata = DATA_W'(r_vclear);
            default:      prdata = '0;
        endcase
    end

    // Input beat and the vertical filter, evaluated on the accepted point.
    assign o_in_stall = r_busy;
    assign w_accept   = i_in_valid && !r_busy;
    assign w_dz       = DIFF_W'(i_point_z) - DIFF_W'(r_goal_z);
    assign w_dz_abs   = w_dz[DIFF_W-1] ? -w_dz : w_dz;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_last <= i_last_point;
            r_zok  <= $unsigned(w_dz_abs) <= DIFF_W'(r_vclear);
        end
    end

    // Microcode sequencer.
    assign w_ctl  = scc_ucode(r_pc);
    assign w_cond = (w_ctl.cond == COND_GOAL) ? w_flags.goal : w_flags.anchor;
    assign w_end  = r_busy && (w_ctl.seq == SEQ_END);
    // The last point of a query waits at its end step until the output is free.
    assign w_fin  = w_end && (!r_last || !r_out_valid || !i_out_stall);
    assign w_near = r_zok && w_flags.acc_nonneg;

    always_comb begin
        n_pc    = r_pc;
        n_busy  = r_busy;
        n_count = r_count;
        if (w_accept) begin
            n_pc   = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            case (w_ctl.seq)
                SEQ_NEXT: n_pc = r_pc + 1'b1;
                SEQ_JUMP: n_pc = w_cond ? w_ctl.tgt : r_pc + 1'b1;
                default:  n_pc = r_pc;
            endcase
        end
        if (w_fin) begin
            n_busy = 1'b0;
            if (w_near && (r_count < CNT_SAT)) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_pc    <= '0;
            r_count <= '0;
        end else begin
            r_busy  <= n_busy;
            r_pc    <= n_pc;
            r_count <= (w_fin && r_last) ? '0 : n_count;
        end
    end

    // Output register for the query result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fin && r_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin && r_last) begin
            r_near       <= n_count;
            r_obstructed <= n_count == CNT_SAT;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_obstructed  = r_obstructed;
    assign o_near_points = r_near;

    scc_datapath u_datapath (
        .i_clk      (i_clk),
        .i_load     (w_accept),
        .i_run      (r_busy),
        .i_point_x  (i_point_x),
        .i_point_y  (i_point_y),
        .i_anchor_x (r_anchor_x),
        .i_anchor_y (r_anchor_y),
        .i_goal_x   (r_goal_x),
        .i_goal_y   (r_goal_y),
        .i_radius   (r_radius),
        .i_ctl      (w_ctl),
        .o_flags    (w_flags)
    );

    // The obstructed flag agrees with the saturated count it reports.
    a_obstructed_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_obstructed == (o_near_points == CNT_SAT)))
        else $error("obstructed flag disagrees with near point count");

    // The running count never passes saturation.
    a_count_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("near point count beyond saturation");

    // A fresh result comes only from the end step of a last point.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_fin && r_last))
        else $error("result raised outside the end of a query");

    // An accepted point starts the program at its first step.
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_busy && (r_pc == '0)))
        else $error("accepted point did not start the sequencer");

endmodule

`default_nettype wire
